>>> rtl/calendar_date_counter_macros.svh
// Assertion macros used by the checker file cdc_checker.sv.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef CALENDAR_DATE_COUNTER_MACROS_SVH
`define CALENDAR_DATE_COUNTER_MACROS_SVH

// A property checked at every clock edge; it may carry its own implication.
`define CDC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The consequent is checked on a later clock edge than the antecedent.
`define CDC_ASSERT_2(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error(msg);

`endif

>>> rtl/cdc_pkg.sv
package cdc_pkg;

	localparam logic [13:0] YEAR_LIMIT = 14'd9999;

	localparam logic [1:0] OP_ADV_DAY   = 2'd0;
	localparam logic [1:0] OP_ADV_MONTH = 2'd1;
	localparam logic [1:0] OP_LOAD      = 2'd2;

	// floor(2^32 / 100) and ceil(2^19 / 100), reciprocals for division by 100.
	localparam logic [25:0] RECIP100_Q32 = 26'd42949672;
	localparam logic [12:0] RECIP100_Q19 = 13'd5243;

	// Month lengths for a common year; codes outside 1 to 12 give zero.
	localparam logic [4:0] MONTH_LEN [16] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
		5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
	};

	typedef struct packed {
		logic [1:0]  op;
		logic [26:0] packed_date;
	} item_t;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic        error;
	} result_t;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} date_t;

	// An item after the first split: packed_date / 100 and packed_date % 100.
	typedef struct packed {
		logic [1:0]  op;
		logic [20:0] hundreds;
		logic [6:0]  units;
	} split_t;

	typedef struct packed {
		logic [20:0] quot;
		logic [6:0]  rem;
	} div_t;

	// Division by 100 through the reciprocal. The estimate is low by at most one,
	// so a single compare and subtract finishes it.
	function automatic div_t div100(input logic [26:0] x);
		logic [52:0] prod;
		logic [20:0] q;
		logic [27:0] r;
		div_t        res;
		prod = 53'(x) * 53'(RECIP100_Q32);
		q = prod[52:32];
		r = 28'(x) - 28'(q) * 28'd100;
		if (r[7:0] >= 8'd100) begin
			res.quot = q + 21'd1;
			res.rem  = 7'(r[7:0] - 8'd100);
		end else begin
			res.quot = q;
			res.rem  = r[6:0];
		end
		return res;
	endfunction

	// Gregorian rule. The reciprocal scaled by 2^19 is exact for every 14-bit year.
	function automatic logic is_leap(input logic [13:0] y);
		logic [26:0] prod;
		logic [7:0]  cent;
		logic [13:0] back;
		prod = 27'(y) * 27'(RECIP100_Q19);
		cent = prod[26:19];
		back = 14'(cent) * 14'd100;
		return (y[1:0] == 2'b00) && ((back != y) || (cent[1:0] == 2'b00));
	endfunction

	function automatic logic [4:0] days_in(input logic leap, input logic [3:0] m);
		if (m == 4'd2 && leap) begin
			return 5'd29;
		end
		return MONTH_LEN[m];
	endfunction

	function automatic logic [13:0] next_year(input logic [13:0] y);
		return (y >= YEAR_LIMIT) ? 14'd0 : y + 14'd1;
	endfunction

endpackage

>>> rtl/calendar_date_counter.sv
// Calendar date counter: keeps one Gregorian date and applies one operation
// per item arriving on the item channel (advance one day, advance one month,
// or load a decimal YYYYMMDD value). Every item yields exactly one result on
// the result channel: the date after the operation and an error bit. On error
// the date is left as it was and the result shows it unchanged.
// Both channels use valid and stall; a transfer happens on a clock edge with
// valid high and stall low.
// An item passes one input register, then the date update into the result
// register; a result stall can hold it in the input register. Throughput is
// one item per clock while result_stall is low; the stored date is updated
// once per item by the logic between those two registers.
// item_stall rises only when both registers are full and result_stall is high;
// a held result stays stable until it is taken, and one more item may wait in
// the input register meanwhile.
// Asynchronous reset (arst_n low) empties both registers and sets the date to
// year 0, month 1, day 1.
module calendar_date_counter (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  cdc_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output cdc_pkg::result_t result
);
	import cdc_pkg::*;

	logic    valid_s1;
	split_t  split_s1;
	div_t    lo_div;
	logic    advance;
	date_t   date_q;
	date_t   nxt_date;
	logic    nxt_err;
	logic    result_valid_q;
	result_t result_q;

	assign item_stall = valid_s1 && result_valid_q && result_stall;
	assign advance    = valid_s1 && !(result_valid_q && result_stall);

	// First split on the way in: day digits and everything above them.
	assign lo_div = div100(item.packed_date);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			split_s1.op       <= item.op;
			split_s1.hundreds <= lo_div.quot;
			split_s1.units    <= lo_div.rem;
		end
	end

	cdc_next u_next (
		.cur   (date_q),
		.split (split_s1),
		.nxt   (nxt_date),
		.err   (nxt_err)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			date_q.year    <= 14'd0;
			date_q.month   <= 4'd1;
			date_q.day     <= 5'd1;
			result_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				date_q         <= nxt_date;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.year  <= nxt_date.year;
			result_q.month <= nxt_date.month;
			result_q.day   <= nxt_date.day;
			result_q.error <= nxt_err;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> rtl/cdc_next.sv
module cdc_next (
	input  cdc_pkg::date_t  cur,
	input  cdc_pkg::split_t split,
	output cdc_pkg::date_t  nxt,
	output logic            err
);
	import cdc_pkg::*;

	logic        cur_leap;
	logic [4:0]  n_cur;
	date_t       rolled;
	logic [4:0]  n_roll;
	div_t        ymd;
	logic        ld_leap;
	logic [4:0]  n_ld;
	logic        ld_bad;
	date_t       ld_date;

	assign cur_leap = is_leap(cur.year);
	assign n_cur    = days_in(cur_leap, cur.month);

	// Next month, day untouched. February follows January only, so the year
	// that decides its length is still the current one.
	always_comb begin
		rolled = cur;
		if (cur.month < 4'd12) begin
			rolled.month = cur.month + 4'd1;
		end else begin
			rolled.month = 4'd1;
			rolled.year  = next_year(cur.year);
		end
	end

	assign n_roll = days_in(cur_leap, rolled.month);

	// Second split of the loaded value: hundreds into year and month.
	assign ymd     = div100({6'd0, split.hundreds});
	assign ld_leap = is_leap(ymd.quot[13:0]);
	assign n_ld    = (ymd.rem > 7'd12) ? 5'd0 : days_in(ld_leap, ymd.rem[3:0]);
	assign ld_bad  = (ymd.quot > 21'(YEAR_LIMIT)) || (n_ld == 5'd0) ||
		(split.units == 7'd0) || (split.units > 7'(n_ld));

	assign ld_date.year  = ymd.quot[13:0];
	assign ld_date.month = ymd.rem[3:0];
	assign ld_date.day   = split.units[4:0];

	always_comb begin
		nxt = cur;
		err = 1'b0;
		unique case (split.op)
			OP_ADV_DAY: begin
				if (n_cur == 5'd0 || cur.day > n_cur) begin
					err = 1'b1;
				end else if (cur.day < n_cur) begin
					nxt.day = cur.day + 5'd1;
				end else begin
					nxt     = rolled;
					nxt.day = 5'd1;
				end
			end
			OP_ADV_MONTH: begin
				nxt = rolled;
				if (cur.day > n_roll) begin
					nxt.day = n_roll;
				end
			end
			OP_LOAD: begin
				if (ld_bad) begin
					err = 1'b1;
				end else begin
					nxt = ld_date;
				end
			end
			default: begin
				err = 1'b1;
			end
		endcase
	end

endmodule

>>> rtl/cdc_checker.sv
`include "calendar_date_counter_macros.svh"

module cdc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input cdc_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_stall,
	input cdc_pkg::result_t result
);
	import cdc_pkg::*;

	logic item_taken;
	logic item_held;
	logic result_held;
	logic date_ok;

	assign item_taken  = item_valid && !item_stall;
	assign item_held   = item_valid && item_stall;
	assign result_held = result_valid && result_stall;
	assign date_ok     = (result.month >= 4'd1) && (result.month <= 4'd12) &&
		(result.day >= 5'd1) && (result.day <= 5'd31) && (result.year <= YEAR_LIMIT);

	// A stalled item stays offered and unchanged until it is taken.
	`CDC_ASSERT(a_item_held, item_held |=> item_valid && $stable(item), "stalled item changed")

	// A stalled result keeps its value until it is taken.
	`CDC_ASSERT(a_result_held, result_held |=> $stable({result_valid, result}), "result changed")

	// The block only pushes back when its result side is blocked.
	`CDC_ASSERT(a_stall_cause, !item_stall || result_stall, "item stalled with result side free")

	// An accepted item must be followed by result_valid high, checked with CDC_ASSERT_2.
	`CDC_ASSERT_2(a_latency, item_taken, result_valid, "no result two cycles after an item")

	// A shown date always has month 1 to 12, day 1 to 31 and a year within YEAR_LIMIT.
	`CDC_ASSERT(a_date_range, !result_valid || date_ok, "result date out of range")

endmodule

bind calendar_date_counter cdc_checker u_cdc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
